### src/dbe_pkg.sv
// Package for the deque/bag engine: request action codes, sequencer states
// and the fixed widths of the channel fields. No dependencies.
`default_nettype none

package dbe_pkg;

  localparam int FIELD_BITS = 32;
  localparam int COUNT_BITS = 5;
  localparam int WIDE_BITS  = 64;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_CONTAINS   = 3'd6,
    ACT_REMOVE     = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### src/dbe_channel_if.sv
// Request and response channel interfaces of the deque/bag engine.
// Depends on dbe_pkg for the field widths.
`default_nettype none

interface dbe_req_if
  import dbe_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   action;
  logic signed [FIELD_BITS-1:0] item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface dbe_rsp_if
  import dbe_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] read_value;
  logic                         found;
  logic                         error;
  logic [COUNT_BITS-1:0]        count;

  modport source (output valid, output read_value, output found, output error,
                  output count, input ready);
  modport sink   (input valid, input read_value, input found, input error,
                  input count, output ready);
endinterface

`default_nettype wire

### src/dbe_ring_slot.sv
// Ring address unit of the deque/bag engine: maps a position counted from the
// front to a storage slot, (base + offset) mod DEPTH. Depends on nothing.
`default_nettype none

module dbe_ring_slot #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic [IDX_W-1:0] base,
  input  wire logic [CNT_W-1:0] offset,
  output logic      [IDX_W-1:0] slot
);

  localparam int SUM_W = CNT_W + 1;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] wrapped;

  // The base is below DEPTH and the offset at most DEPTH, so one conditional subtract wraps the sum.
  always_comb begin
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      wrapped = sum - SUM_W'(DEPTH);
    end else begin
      wrapped = sum;
    end
  end

  assign slot = wrapped[IDX_W-1:0];

endmodule

`default_nettype wire

### src/deque_bag_engine_core.sv
// Top level of the deque/bag engine: ring storage, sequencer and result register.
// Depends on dbe_pkg, dbe_channel_if and dbe_ring_slot.
//
//   channel | direction | fields
//   --------+-----------+------------------------------------------
//   req     | in        | action, item_value
//   rsp     | out       | read_value, found, error, count
//
// A push goes from S_EXEC to S_DONE; a pop or peek reads the ring in S_EXEC and
// takes the value in S_READ. A contains or remove scans each element in S_SCAN_RD
// and S_SCAN_CMP through the single read port of the ring memory, and a remove
// then moves each later element in S_SHIFT_RD and S_SHIFT_WR. One request is in
// work at a time; req.ready is high only while the sequencer is idle. A finished
// result waits in its state until the response register is free. Synchronous
// reset empties the deque; the memory contents need no clearing.
`default_nettype none

module deque_bag_engine_core
  import dbe_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  dbe_req_if.sink  req,
  dbe_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t                state, state_next;
  act_t                  act;
  logic [VALUE_BITS-1:0] val;
  logic [IDX_W-1:0]      front, front_next;
  logic [CNT_W-1:0]      held_count, held_count_next;
  logic [CNT_W-1:0]      pos, pos_next;
  logic [CNT_W-1:0]      pos_inc;
  logic [VALUE_BITS-1:0] res_value, res_value_next;
  logic                  res_found, res_found_next;
  logic                  res_error, res_error_next;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] mem_rdata;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_we;

  logic [CNT_W-1:0]      slot_offset;
  logic [IDX_W-1:0]      slot;

  logic [WIDE_BITS-1:0]  item_wide;
  logic [WIDE_BITS-1:0]  res_wide;
  logic                  is_full, is_empty;
  logic                  out_free;

  dbe_ring_slot #(.DEPTH(DEPTH)) u_slot (
    .base   (front),
    .offset (slot_offset),
    .slot   (slot)
  );

  assign item_wide = {{(WIDE_BITS - FIELD_BITS){1'b0}}, req.item_value};
  assign res_wide  = WIDE_BITS'(res_value);
  assign is_full   = (held_count == CNT_W'(DEPTH));
  assign is_empty  = (held_count == '0);
  assign pos_inc   = pos + CNT_W'(1);
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    front_next      = front;
    held_count_next = held_count;
    pos_next        = pos;
    res_value_next  = res_value;
    res_found_next  = res_found;
    res_error_next  = res_error;
    slot_offset     = '0;
    mem_we          = 1'b0;
    mem_wdata       = val;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_value_next = '0;
          res_found_next = 1'b0;
          res_error_next = 1'b0;
          state_next     = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (act)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            // Stepping forward DEPTH-1 places around the ring is the decrement.
            slot_offset = (act == ACT_PUSH_FRONT) ? CNT_W'(DEPTH - 1) : held_count;
            if (is_full) begin
              res_error_next = 1'b1;
            end else begin
              mem_we          = 1'b1;
              held_count_next = held_count + CNT_W'(1);
              if (act == ACT_PUSH_FRONT) begin
                front_next = slot;
              end
            end
            state_next = S_DONE;
          end
          ACT_POP_FRONT, ACT_PEEK_FRONT, ACT_POP_BACK, ACT_PEEK_BACK: begin
            if (act == ACT_POP_BACK || act == ACT_PEEK_BACK) begin
              slot_offset = held_count - CNT_W'(1);
            end
            if (is_empty) begin
              res_error_next = 1'b1;
              state_next     = S_DONE;
            end else begin
              state_next = S_READ;
            end
          end
          ACT_CONTAINS, ACT_REMOVE: begin
            pos_next = '0;
            if (is_empty) begin
              res_error_next = 1'b1;
              state_next     = S_DONE;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_READ: begin
        res_value_next = mem_rdata;
        slot_offset    = CNT_W'(1);
        if (act == ACT_POP_FRONT) begin
          front_next      = slot;
          held_count_next = held_count - CNT_W'(1);
        end else if (act == ACT_POP_BACK) begin
          held_count_next = held_count - CNT_W'(1);
        end
        state_next = S_DONE;
      end

      S_SCAN_RD: begin
        slot_offset = pos;
        state_next  = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (mem_rdata == val) begin
          res_found_next = 1'b1;
          state_next     = (act == ACT_REMOVE) ? S_SHIFT_RD : S_DONE;
        end else if (pos_inc == held_count) begin
          state_next = S_DONE;
        end else begin
          pos_next   = pos_inc;
          state_next = S_SCAN_RD;
        end
      end

      // Close the gap: each later element moves one place toward the front.
      S_SHIFT_RD: begin
        slot_offset = pos_inc;
        if (pos_inc < held_count) begin
          state_next = S_SHIFT_WR;
        end else begin
          held_count_next = held_count - CNT_W'(1);
          state_next      = S_DONE;
        end
      end

      S_SHIFT_WR: begin
        slot_offset = pos;
        mem_we      = 1'b1;
        mem_wdata   = mem_rdata;
        pos_next    = pos_inc;
        state_next  = S_SHIFT_RD;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      held_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state      <= state_next;
      front      <= front_next;
      held_count <= held_count_next;
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      act <= act_t'(req.action);
      val <= item_wide[VALUE_BITS-1:0];
    end
    pos       <= pos_next;
    res_value <= res_value_next;
    res_found <= res_found_next;
    res_error <= res_error_next;
    if (state == S_DONE && out_free) begin
      rsp.read_value <= res_wide[FIELD_BITS-1:0];
      rsp.found      <= res_found;
      rsp.error      <= res_error;
      rsp.count      <= COUNT_BITS'(held_count);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot] <= mem_wdata;
    end
    mem_rdata <= mem[slot];
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for deque_bag_engine_core: directed and random requests
// against an in-bench model of the bounded deque. Needs dbe_pkg and dbe_channel_if.
`default_nettype none

module tb_top
  import dbe_pkg::*;
;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int RAND_ITEMS = 280;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] read_value;
    logic                         found;
    logic                         error;
    logic [COUNT_BITS-1:0]        count;
  } deque_result_t;

  logic clk;
  logic rst;

  dbe_req_if req_ch ();
  dbe_rsp_if rsp_ch ();

  deque_bag_engine_core #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the deque contents.
  logic signed [FIELD_BITS-1:0] ring_mem [DEPTH];
  int                           ring_front;
  int                           ring_held;

  deque_result_t pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int fail_count;
  int sent_count;
  int checked_count;
  int search_hits;
  int error_results;
  bit fill_mode;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int slot_of(int pos);
    return (ring_front + pos) % DEPTH;
  endfunction

  // Applies one request to the shadow deque and returns the result it must give.
  function automatic deque_result_t apply_request(act_t act, logic signed [FIELD_BITS-1:0] val);
    deque_result_t res;
    int            k;
    int            i;
    res = '0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (ring_held >= DEPTH) begin
          res.error = 1'b1;
        end else if (act == ACT_PUSH_FRONT) begin
          ring_front = (ring_front + DEPTH - 1) % DEPTH;
          ring_mem[ring_front] = val;
          ring_held++;
        end else begin
          ring_mem[slot_of(ring_held)] = val;
          ring_held++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (ring_held == 0) begin
          res.error = 1'b1;
        end else begin
          if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT)
            res.read_value = ring_mem[slot_of(0)];
          else
            res.read_value = ring_mem[slot_of(ring_held - 1)];
          if (act == ACT_POP_FRONT) begin
            ring_front = (ring_front + 1) % DEPTH;
            ring_held--;
          end else if (act == ACT_POP_BACK) begin
            ring_held--;
          end
        end
      end
      default: begin
        if (ring_held == 0) begin
          res.error = 1'b1;
        end else begin
          k = 0;
          while (k < ring_held && ring_mem[slot_of(k)] != val) k++;
          if (k < ring_held) begin
            res.found = 1'b1;
            // A removal closes the gap by moving every later element one step forward.
            if (act == ACT_REMOVE) begin
              for (i = k; i + 1 < ring_held; i++)
                ring_mem[slot_of(i)] = ring_mem[slot_of(i + 1)];
              ring_held--;
            end
          end
        end
      end
    endcase
    res.count = ring_held[COUNT_BITS-1:0];
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(act_t act, logic signed [FIELD_BITS-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.item_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_request(act, val));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Response side: random stalls, long hold-offs on request, and the result check.
  initial begin
    deque_result_t want;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (want.found) search_hits++;
          if (want.error) error_results++;
          if (rsp_ch.read_value !== want.read_value) begin
            $error("read_value expected %0d got %0d", want.read_value, rsp_ch.read_value);
            fail_count++;
          end
          if (rsp_ch.found !== want.found) begin
            $error("found expected %0b got %0b", want.found, rsp_ch.found);
            fail_count++;
          end
          if (rsp_ch.error !== want.error) begin
            $error("error expected %0b got %0b", want.error, rsp_ch.error);
            fail_count++;
          end
          if (rsp_ch.count !== want.count) begin
            $error("count expected %0d got %0d", want.count, rsp_ch.count);
            fail_count++;
          end
        end
      end
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic signed [FIELD_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    // Reusing held values keeps contains and remove hitting at every depth.
    if (r < 45 && ring_held > 0)
      return ring_mem[slot_of($urandom_range(0, ring_held - 1))];
    else if (r < 70)
      return $urandom_range(0, 7);
    else
      return $urandom;
  endfunction

  task automatic test_empty_requests();
    send_request(ACT_POP_FRONT, 32'sd0);
    send_request(ACT_POP_BACK, 32'sd0);
    send_request(ACT_PEEK_FRONT, 32'sd0);
    send_request(ACT_PEEK_BACK, 32'sd0);
    send_request(ACT_CONTAINS, 32'sd0);
    send_request(ACT_REMOVE, -32'sd1);
  endtask

  task automatic test_ends_and_search();
    send_request(ACT_PUSH_BACK, 32'sh8000_0000);
    send_request(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(ACT_PUSH_BACK, 32'sd0);
    send_request(ACT_PUSH_FRONT, -32'sd1);
    send_request(ACT_PUSH_BACK, 32'sd5);
    send_request(ACT_PUSH_BACK, 32'sd5);
    send_request(ACT_CONTAINS, 32'sd5);
    send_request(ACT_CONTAINS, 32'sd99);
    send_request(ACT_REMOVE, 32'sd5);
    send_request(ACT_REMOVE, 32'sd77);
    send_request(ACT_PEEK_FRONT, 32'sd0);
    send_request(ACT_PEEK_BACK, 32'sd0);
    send_request(ACT_POP_FRONT, 32'sd0);
    send_request(ACT_POP_BACK, 32'sd0);
  endtask

  // Fills the ring to the top so pushes are refused and searches walk every entry.
  task automatic test_full_ring();
    logic signed [FIELD_BITS-1:0] last_value;
    last_value = 32'sh5a5a_a5a5;
    while (ring_held < DEPTH - 1)
      send_request($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom);
    send_request(ACT_PUSH_BACK, last_value);
    send_request(ACT_PUSH_FRONT, 32'sd1);
    send_request(ACT_PUSH_BACK, 32'sd2);
    send_request(ACT_CONTAINS, last_value);
    send_request(ACT_REMOVE, last_value);
    send_request(ACT_PEEK_BACK, 32'sd0);
  endtask

  task automatic test_backpressure();
    int n;
    wait_drained();
    send_idle_pct = 0;
    hold_left     = 150;
    for (n = 0; n < 12; n++)
      send_request(n % 3 == 0 ? ACT_CONTAINS : ACT_PUSH_BACK, pick_value());
    wait_drained();
  endtask

  task automatic test_random(int send_pct, int stall_pct);
    int   n;
    int   r;
    act_t act;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (ring_held == DEPTH) fill_mode = 1'b0;
      if (ring_held == 0)     fill_mode = 1'b1;
      r = $urandom_range(0, 99);
      // Drift the fill level between empty and full so both ends get exercised.
      if (r < 40) begin
        if (fill_mode)
          act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else
          act = act_t'($urandom_range(0, 2) == 0 ? ACT_REMOVE : $urandom_range(2, 3));
      end else begin
        act = act_t'($urandom_range(0, 7));
      end
      send_request(act, pick_value());
    end
    wait_drained();
  endtask

  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_PUSH_FRONT;
    req_ch.item_value = '0;
    ring_front        = 0;
    ring_held         = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_left         = 0;
    fail_count        = 0;
    sent_count        = 0;
    checked_count     = 0;
    search_hits       = 0;
    error_results     = 0;
    fill_mode         = 1'b1;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_requests();
    test_ends_and_search();
    test_full_ring();
    test_backpressure();
    test_random(0, 0);
    test_random(67, 0);
    test_random(0, 67);
    test_random(22, 22);

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Sent %0d requests and checked %0d results under four idle mixes.",
             sent_count, checked_count);
    $display("Search hits: %0d, full or empty refusals: %0d.", search_hits, error_results);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/dbe_pkg.sv
src/dbe_channel_if.sv
src/dbe_ring_slot.sv
src/deque_bag_engine_core.sv
tb/tb_top.sv
